>>> src/refcounted_token_table_top_defines.svh
// assertion macros for the token table
`ifndef REFCOUNTED_TOKEN_TABLE_TOP_DEFINES_SVH
`define REFCOUNTED_TOKEN_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RTT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("rtt check");
`define RTT_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) else $error("rtt reset check");
`else
`define RTT_ASSERT(label, prop)
`define RTT_ASSERT_RST(label, prop)
`endif
`endif

>>> src/rtt_pkg.sv
package rtt_pkg;
    localparam int GLOBAL_SLOTS = 16;
    localparam int SLOTS_PER_PROC = 8;
    localparam int PROCS = 64;
    localparam int MAX_RESULTS = 8;
    localparam int GW = $clog2(GLOBAL_SLOTS);
    localparam int SW = (SLOTS_PER_PROC > 1) ? $clog2(SLOTS_PER_PROC) : 1;
    localparam int PW = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int NW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int PDEPTH = PROCS * SLOTS_PER_PROC;
    localparam int AW = $clog2(PDEPTH);
    localparam logic [6:0] REFS_MAX = 7'd127;

    localparam logic [1:0] ACT_GET = 2'd0;
    localparam logic [1:0] ACT_DEL = 2'd1;
    localparam logic [1:0] ACT_DEL_ALL = 2'd2;
    localparam logic [1:0] ACT_CHECK = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD = 3'd1;
    localparam logic [2:0] ST_HELD = 3'd2;
    localparam logic [2:0] ST_PFULL = 3'd3;
    localparam logic [2:0] ST_GFULL = 3'd4;
    localparam logic [2:0] ST_NOTHELD = 3'd5;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] global_slot;
        logic [6:0] ref_count;
        logic       slot_created;
        logic       slot_freed;
        logic       held;
        logic       last;
    } result_t;
endpackage

>>> src/rtt_global_table.sv
// global tag table, read and written through a single index
module rtt_global_table
    import rtt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [GW-1:0] idx,
    output logic          vld,
    output logic [15:0]   tag,
    output logic [6:0]    refs,
    input  logic          wr,
    input  logic          wr_vld,
    input  logic [15:0]   wr_tag,
    input  logic [6:0]    wr_refs
);
    logic [GLOBAL_SLOTS-1:0] valid_reg;
    logic [15:0]             tag_reg [GLOBAL_SLOTS];
    logic [6:0]              refs_reg [GLOBAL_SLOTS];

    assign vld = valid_reg[idx];
    assign tag = tag_reg[idx];
    assign refs = refs_reg[idx];

    // entry write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < GLOBAL_SLOTS; i++)
                refs_reg[i] <= '0;
        end
        else if (wr)
        begin
            valid_reg[idx] <= wr_vld;
            refs_reg[idx] <= wr_refs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            tag_reg[idx] <= wr_tag;
    end
endmodule

>>> src/refcounted_token_table_top.sv
// refcounted token table
// input channel s_axis: one transaction is one request (get, delete, delete
// all, check) for a process and a token. output channel m_axis: one or more
// result transactions per request, tlast on the last one.
// a sequencer walks the process slots through the process memory (one read
// port, a read state and a check state per slot), decides in one state,
// then walks the global table one entry per cycle through a single tag
// comparator (up to 16 entries, plus up to 16 more to find a free entry for
// a new token) and updates in one state.
// a new request is taken only in the idle state, once every result of the
// request before it has been taken.
// a delete all releases the held slots one at a time with a result each,
// skipping the empty ones; no new request is taken until the last result
// is taken.
// after reset a clearing pass over all PROCS*SLOTS_PER_PROC words (512)
// zeroes the process memory; s_axis_tready stays low meanwhile.
// results sit in an output register; when the receiver stalls the sequencer
// waits and nothing is lost.
`include "refcounted_token_table_top_defines.svh"
module refcounted_token_table_top
    import rtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // action[1:0], proc_id[7:2], token[23:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[2:0], global_slot[6:3], ref_count[13:7],
                                        // slot_created[14], slot_freed[15], held[16],
                                        // zero[23:17]
    output logic        m_axis_tlast
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PRD, S_PCHK, S_DECIDE, S_GFIND, S_GFREE,
        S_ACT, S_DSEL, S_DRD, S_DTAG, S_OUT
    } state_t;

    state_t state_reg;
    logic [AW-1:0] clr_reg;
    logic [1:0] act_reg;
    logic [PW-1:0] proc_reg;
    logic [15:0] tok_reg;
    logic [SW-1:0] pi_reg;
    logic [SW-1:0] found_reg, freep_reg;
    logic found_v_reg, freep_v_reg;
    logic [SLOTS_PER_PROC-1:0] mask_reg;
    logic [GW-1:0] gi_reg;
    logic [GW-1:0] g_reg;
    logic g_v_reg;
    logic [NW-1:0] ndone_reg;
    logic more_reg;
    logic [23:0] out_data_reg;
    logic out_valid_reg, out_last_reg;

    function automatic logic [23:0] pack_result(result_t r);
        return {7'd0, r.held, r.slot_freed, r.slot_created, r.ref_count,
                r.global_slot, r.status};
    endfunction

    function automatic logic [23:0] err_data(logic [2:0] st);
        result_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return pack_result(r);
    endfunction

    // process memory: valid bits and tags in one word
    logic [16:0] pmem [PDEPTH];
    logic [16:0] prd_reg;
    logic pwr;
    logic [AW-1:0] paddr;
    logic [16:0] pwdata;

    always_ff @(posedge clk)
    begin
        if (pwr)
            pmem[paddr] <= pwdata;
        prd_reg <= pmem[paddr];
    end

    // global table
    logic [GW-1:0] gidx;
    logic gvld, gwr, gwvld;
    logic [15:0] gtag;
    logic [6:0] grefs, gwrefs;
    rtt_global_table u_gt (
        .clk(clk), .rst_n(rst_n), .idx(gidx), .vld(gvld), .tag(gtag), .refs(grefs),
        .wr(gwr), .wr_vld(gwvld), .wr_tag(tok_reg), .wr_refs(gwrefs)
    );
    logic gmatch;
    assign gmatch = gvld && (gtag == tok_reg);

    logic [AW-1:0] base;
    assign base = AW'(proc_reg) * AW'(SLOTS_PER_PROC);

    // memory and table control, result of the update step
    result_t act_r;
    logic [6:0] dec_refs;

    always_comb
    begin
        pwr = 1'b0;
        pwdata = '0;
        paddr = base + AW'(pi_reg);
        gidx = gi_reg;
        gwr = 1'b0;
        gwvld = 1'b0;
        gwrefs = grefs;
        dec_refs = (grefs != 7'd0) ? grefs - 7'd1 : 7'd0;
        act_r = '0;
        act_r.last = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                paddr = clr_reg;
                pwr = 1'b1;
            end
            S_ACT:
            begin
                gidx = g_reg;
                case (act_reg)
                    ACT_GET:
                    begin
                        if (g_v_reg && grefs >= REFS_MAX)
                            act_r.status = ST_GFULL;
                        else
                        begin
                            paddr = base + AW'(freep_reg);
                            pwr = 1'b1;
                            pwdata = {1'b1, tok_reg};
                            gwr = 1'b1;
                            gwvld = 1'b1;
                            gwrefs = g_v_reg ? grefs + 7'd1 : 7'd1;
                            act_r.global_slot = 4'(g_reg);
                            act_r.ref_count = gwrefs;
                            act_r.slot_created = !g_v_reg;
                        end
                    end
                    ACT_CHECK:
                    begin
                        act_r.held = 1'b1;
                        if (g_v_reg)
                        begin
                            act_r.global_slot = 4'(g_reg);
                            act_r.ref_count = grefs;
                        end
                    end
                    // delete and delete all
                    default:
                    begin
                        paddr = base + AW'(found_reg);
                        pwr = 1'b1;
                        if (g_v_reg)
                        begin
                            gwr = 1'b1;
                            gwrefs = dec_refs;
                            gwvld = (dec_refs != 7'd0);
                            act_r.global_slot = 4'(g_reg);
                            act_r.ref_count = dec_refs;
                            act_r.slot_freed = (dec_refs == 7'd0);
                        end
                        act_r.last = (act_reg != ACT_DEL_ALL) || (mask_reg == '0)
                            || (ndone_reg == NW'(MAX_RESULTS - 1));
                    end
                endcase
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
            out_data_reg <= '0;
            act_reg <= '0; proc_reg <= '0; tok_reg <= '0;
            pi_reg <= '0; gi_reg <= '0; found_reg <= '0; freep_reg <= '0;
            found_v_reg <= 1'b0; freep_v_reg <= 1'b0; g_reg <= '0; g_v_reg <= 1'b0;
            mask_reg <= '0; ndone_reg <= '0; more_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(PDEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        act_reg <= s_axis_tdata[1:0];
                        proc_reg <= PW'(int'(s_axis_tdata[7:2]) % PROCS);
                        tok_reg <= s_axis_tdata[23:8];
                        pi_reg <= '0;
                        found_v_reg <= 1'b0;
                        freep_v_reg <= 1'b0;
                        state_reg <= S_PRD;
                    end
                end
                // issue read of slot pi
                S_PRD: state_reg <= S_PCHK;
                // check one process slot from the registered read
                S_PCHK:
                begin
                    mask_reg[pi_reg] <= prd_reg[16];
                    if (prd_reg[16])
                    begin
                        if (!found_v_reg && prd_reg[15:0] == tok_reg)
                        begin
                            found_v_reg <= 1'b1;
                            found_reg <= pi_reg;
                        end
                    end
                    else if (!freep_v_reg)
                    begin
                        freep_v_reg <= 1'b1;
                        freep_reg <= pi_reg;
                    end
                    if (pi_reg == SW'(SLOTS_PER_PROC - 1))
                        state_reg <= S_DECIDE;
                    else
                    begin
                        pi_reg <= pi_reg + 1'b1;
                        state_reg <= S_PRD;
                    end
                end
                S_DECIDE:
                begin
                    gi_reg <= '0;
                    g_v_reg <= 1'b0;
                    pi_reg <= '0;
                    ndone_reg <= '0;
                    more_reg <= 1'b0;
                    if (act_reg == ACT_DEL_ALL)
                    begin
                        if (mask_reg == '0)
                        begin
                            out_data_reg <= err_data(ST_NOTHELD); out_last_reg <= 1'b1;
                            out_valid_reg <= 1'b1; state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_DSEL;
                    end
                    else if (tok_reg[15])
                    begin
                        out_data_reg <= err_data(ST_BAD); out_last_reg <= 1'b1;
                        out_valid_reg <= 1'b1; state_reg <= S_OUT;
                    end
                    else if (act_reg == ACT_GET && found_v_reg)
                    begin
                        out_data_reg <= err_data(ST_HELD); out_last_reg <= 1'b1;
                        out_valid_reg <= 1'b1; state_reg <= S_OUT;
                    end
                    else if (act_reg == ACT_GET && !freep_v_reg)
                    begin
                        out_data_reg <= err_data(ST_PFULL); out_last_reg <= 1'b1;
                        out_valid_reg <= 1'b1; state_reg <= S_OUT;
                    end
                    else if (act_reg != ACT_GET && !found_v_reg)
                    begin
                        out_data_reg <= err_data(ST_NOTHELD); out_last_reg <= 1'b1;
                        out_valid_reg <= 1'b1; state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_GFIND;
                end
                // search global table for the token, one entry per cycle
                S_GFIND:
                begin
                    if (gmatch)
                    begin
                        g_v_reg <= 1'b1;
                        g_reg <= gi_reg;
                        state_reg <= S_ACT;
                    end
                    else if (gi_reg == GW'(GLOBAL_SLOTS - 1))
                    begin
                        if (act_reg == ACT_GET)
                        begin
                            gi_reg <= '0;
                            state_reg <= S_GFREE;
                        end
                        else
                            state_reg <= S_ACT;
                    end
                    else
                        gi_reg <= gi_reg + 1'b1;
                end
                // first free global entry for a new token
                S_GFREE:
                begin
                    if (!gvld)
                    begin
                        g_reg <= gi_reg;
                        state_reg <= S_ACT;
                    end
                    else if (gi_reg == GW'(GLOBAL_SLOTS - 1))
                    begin
                        out_data_reg <= err_data(ST_GFULL); out_last_reg <= 1'b1;
                        out_valid_reg <= 1'b1; state_reg <= S_OUT;
                    end
                    else
                        gi_reg <= gi_reg + 1'b1;
                end
                S_ACT:
                begin
                    out_data_reg <= pack_result(act_r);
                    out_last_reg <= act_r.last;
                    out_valid_reg <= 1'b1;
                    more_reg <= !act_r.last;
                    state_reg <= S_OUT;
                end
                // delete all: skip to the next held slot
                S_DSEL:
                begin
                    if (mask_reg[pi_reg])
                        state_reg <= S_DRD;
                    else
                        pi_reg <= pi_reg + 1'b1;
                end
                S_DRD: state_reg <= S_DTAG;
                S_DTAG:
                begin
                    tok_reg <= prd_reg[15:0];
                    found_reg <= pi_reg;
                    mask_reg[pi_reg] <= 1'b0;
                    gi_reg <= '0;
                    g_v_reg <= 1'b0;
                    state_reg <= S_GFIND;
                end
                // hold the result until the receiver takes it
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (more_reg)
                        begin
                            ndone_reg <= ndone_reg + 1'b1;
                            state_reg <= S_DSEL;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;

    `RTT_ASSERT(a_busy_no_ready, (state_reg != S_IDLE) |-> !s_axis_tready)
    `RTT_ASSERT(a_out_held, out_valid_reg |-> (state_reg == S_OUT))
    `RTT_ASSERT(a_err_last, (out_valid_reg && out_data_reg[2:0] != ST_OK) |-> out_last_reg)
    `RTT_ASSERT(a_freed_zero, (out_valid_reg && out_data_reg[15]) |-> out_data_reg[13:7] == 7'd0)
    `RTT_ASSERT_RST(a_rst_quiet, !rst_n |-> !m_axis_tvalid)
endmodule

>>> verif/refcounted_token_table_top_tb.sv
module refcounted_token_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtt_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int MAX_REPORTS = 10;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // action[1:0], proc_id[7:2], token[23:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // status[2:0], global_slot[6:3], ref_count[13:7],
                                 // slot_created[14], slot_freed[15], held[16], zero[23:17]
    logic        m_axis_tlast;

    // shadow copy of the token tables
    logic            tbl_valid [GLOBAL_SLOTS];
    logic [15:0]     tbl_tag [GLOBAL_SLOTS];
    logic [6:0]      tbl_refs [GLOBAL_SLOTS];
    logic            own_valid [PDEPTH];
    logic [15:0]     own_tag [PDEPTH];

    result_t         pending_results[$];
    int              mismatches;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_cycles;
    int              quiet_cycles;

    refcounted_token_table_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic result_t make_result(logic [2:0] st, logic [3:0] slot, logic [6:0] refs,
                                            logic created, logic freed, logic held,
                                            logic last);
        result_t r;
        r.status       = st;
        r.global_slot  = slot;
        r.ref_count    = refs;
        r.slot_created = created;
        r.slot_freed   = freed;
        r.held         = held;
        r.last         = last;
        return r;
    endfunction

    // single error result of a request
    function automatic result_t err_result(logic [2:0] st);
        return make_result(st, 4'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    endfunction

    function automatic int lookup_tag(logic [15:0] tag);
        for (int i = 0; i < GLOBAL_SLOTS; i++)
            if (tbl_valid[i] && tbl_tag[i] == tag)
                return i;
        return -1;
    endfunction

    // release one reference, return the result it reports
    function automatic result_t release_ref(logic [15:0] tag, logic last);
        int g;
        g = lookup_tag(tag);
        if (g < 0)
            return make_result(ST_OK, 4'd0, 7'd0, 1'b0, 1'b0, 1'b0, last);
        if (tbl_refs[g] > 7'd0)
            tbl_refs[g] = tbl_refs[g] - 7'd1;
        if (tbl_refs[g] == 7'd0)
        begin
            tbl_valid[g] = 1'b0;
            return make_result(ST_OK, g[3:0], 7'd0, 1'b0, 1'b1, 1'b0, last);
        end
        return make_result(ST_OK, g[3:0], tbl_refs[g], 1'b0, 1'b0, 1'b0, last);
    endfunction

    // work out the results of one request and queue them
    task automatic predict_request(logic [1:0] action, logic [5:0] proc, logic [15:0] tag);
        int base;
        int found;
        int freep;
        int g;
        int n;
        int idx [MAX_RESULTS];
        base = int'(proc) % PROCS * SLOTS_PER_PROC;
        found = -1;
        freep = -1;
        n = 0;
        for (int i = 0; i < SLOTS_PER_PROC; i++)
        begin
            if (own_valid[base + i])
            begin
                if (found < 0 && own_tag[base + i] == tag)
                    found = i;
            end
            else if (freep < 0)
                freep = i;
        end
        if (action == ACT_DEL_ALL)
        begin
            for (int i = 0; i < SLOTS_PER_PROC && n < MAX_RESULTS; i++)
                if (own_valid[base + i])
                begin
                    idx[n] = i;
                    n++;
                end
            if (n == 0)
                pending_results.push_back(err_result(ST_NOTHELD));
            for (int i = 0; i < n; i++)
            begin
                own_valid[base + idx[i]] = 1'b0;
                pending_results.push_back(release_ref(own_tag[base + idx[i]], i == n - 1));
            end
        end
        else if (tag[15])
            pending_results.push_back(err_result(ST_BAD));
        else if (action == ACT_GET)
        begin
            if (found >= 0)
                pending_results.push_back(err_result(ST_HELD));
            else if (freep < 0)
                pending_results.push_back(err_result(ST_PFULL));
            else
            begin
                g = lookup_tag(tag);
                if (g >= 0 && tbl_refs[g] >= REFS_MAX)
                    pending_results.push_back(err_result(ST_GFULL));
                else if (g >= 0)
                begin
                    tbl_refs[g] = tbl_refs[g] + 7'd1;
                    own_valid[base + freep] = 1'b1;
                    own_tag[base + freep] = tag;
                    pending_results.push_back(make_result(ST_OK, g[3:0], tbl_refs[g],
                                                          1'b0, 1'b0, 1'b0, 1'b1));
                end
                else
                begin
                    g = -1;
                    for (int i = GLOBAL_SLOTS - 1; i >= 0; i--)
                        if (!tbl_valid[i])
                            g = i;
                    if (g < 0)
                        pending_results.push_back(err_result(ST_GFULL));
                    else
                    begin
                        tbl_valid[g] = 1'b1;
                        tbl_tag[g] = tag;
                        tbl_refs[g] = 7'd1;
                        own_valid[base + freep] = 1'b1;
                        own_tag[base + freep] = tag;
                        pending_results.push_back(make_result(ST_OK, g[3:0], 7'd1,
                                                              1'b1, 1'b0, 1'b0, 1'b1));
                    end
                end
            end
        end
        else if (action == ACT_DEL)
        begin
            if (found < 0)
                pending_results.push_back(err_result(ST_NOTHELD));
            else
            begin
                own_valid[base + found] = 1'b0;
                pending_results.push_back(release_ref(tag, 1'b1));
            end
        end
        else if (found < 0)
            pending_results.push_back(err_result(ST_NOTHELD));
        else
        begin
            g = lookup_tag(tag);
            if (g < 0)
                pending_results.push_back(make_result(ST_OK, 4'd0, 7'd0, 1'b0, 1'b0, 1'b1, 1'b1));
            else
                pending_results.push_back(make_result(ST_OK, g[3:0], tbl_refs[g],
                                                      1'b0, 1'b0, 1'b1, 1'b1));
        end
    endtask

    // offer one request and wait for its transaction
    task automatic send_request(logic [1:0] action, logic [5:0] proc, logic [15:0] tag);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tag, proc, action};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_request(action, proc, tag);
    endtask

    // lower valid and wait until every queued result has come
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_request;
        logic [1:0]  action;
        logic [5:0]  proc;
        logic [15:0] tag;
        action = $urandom_range(3);
        if (action == ACT_GET && $urandom_range(1))
            action = ACT_GET;
        proc = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(5));
        case ($urandom_range(9))
            0:       tag = 16'($urandom);
            1:       tag = 16'h8000 | 16'($urandom);
            default: tag = 16'($urandom_range(23));
        endcase
        send_request(action, proc, tag);
    endtask

    // directed: field extremes and the bad, held, not held and process full statuses
    task automatic test_directed;
        send_request(ACT_DEL_ALL, 6'd0, 16'h0000);
        send_request(ACT_GET, 6'd0, 16'h0000);
        send_request(ACT_GET, 6'd0, 16'h0000);
        send_request(ACT_GET, 6'd63, 16'h7fff);
        send_request(ACT_GET, 6'd63, 16'h0000);
        send_request(ACT_GET, 6'd1, 16'hffff);
        send_request(ACT_DEL, 6'd1, 16'h8000);
        send_request(ACT_CHECK, 6'd2, 16'h8000);
        send_request(ACT_CHECK, 6'd0, 16'h0000);
        send_request(ACT_CHECK, 6'd1, 16'h0000);
        send_request(ACT_DEL, 6'd1, 16'h0000);
        send_request(ACT_DEL, 6'd63, 16'h0000);
        send_request(ACT_CHECK, 6'd0, 16'h0000);
        for (int i = 0; i < 9; i++)
            send_request(ACT_GET, 6'd5, 16'(40 + i));
        send_request(ACT_DEL_ALL, 6'd5, 16'hffff);
        drain();
    endtask

    // fill the global table, ask for more, then empty it again
    task automatic test_global_full;
        for (int i = 0; i < GLOBAL_SLOTS + 1; i++)
            send_request(ACT_GET, 6'(10 + i), 16'(300 + i));
        for (int i = 0; i < GLOBAL_SLOTS + 1; i++)
            send_request(ACT_DEL_ALL, 6'(10 + i), 16'h0000);
        send_request(ACT_DEL_ALL, 6'd0, 16'h0000);
        send_request(ACT_DEL_ALL, 6'd63, 16'h0000);
        drain();
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure;
        hold_cycles = 300;
        for (int i = 0; i < 10; i++)
            send_request(ACT_GET, 6'($urandom_range(3)), 16'($urandom_range(7)));
        drain();
    endtask

    task automatic test_random(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
            random_request();
        drain();
    endtask

    // receiver ready, with random idling and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        result_t got_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_r = make_result(m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[13:7],
                                m_axis_tdata[14], m_axis_tdata[15], m_axis_tdata[16],
                                m_axis_tlast);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transaction: %p", got_r);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r != got_r)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result mismatch: expected %p actual %p", exp_r, got_r);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("refcounted_token_table_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < GLOBAL_SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_tag[i]   = '0;
            tbl_refs[i]  = '0;
        end
        for (int i = 0; i < PDEPTH; i++)
        begin
            own_valid[i] = 1'b0;
            own_tag[i]   = '0;
        end
        mismatches    = 0;
        quiet_cycles  = 0;
        hold_cycles   = 0;
        send_idle_pct = 32;
        recv_idle_pct = 54;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_global_full();
        test_backpressure();
        test_random(12, 32, 54);
        test_random(12, 54, 32);
        test_random(12, 0, 0);

        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("refcounted_token_table_top_tb: clean");
        else
            $display("refcounted_token_table_top_tb: errors");
        $finish;
    end
endmodule
